@@ hw/rtl/tsma_pkg.sv @@
`default_nettype none

package tsma_pkg;

  // Window length of the boxcar average.
  localparam int WINDOW = 10;

  // Field widths.
  localparam int CODE_W = 12;
  localparam int TEMP_W = 19;
  localparam int FILL_W = 4;

  // Internal widths that follow from the window.
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = TEMP_W + $clog2(WINDOW + 1);

  // Restoring divider for the average: every quotient fits in QW bits.
  localparam int QW    = 18;
  localparam int CNT_DW = $clog2(QW);
  localparam int DIV_W = 36;

  // Code to temperature: x = code * 3300 - 2891776, and
  // temp = 2700 - round(x * 3125 / 220288), ties away from zero.
  localparam int X_W = 25;
  localparam int XMAG_W = 24;
  localparam logic [XMAG_W-1:0] CONV_MUL    = 24'd3300;
  localparam logic [X_W-1:0]    CONV_OFFSET = 25'd2891776;
  localparam logic [11:0]       CONV_K2     = 12'd3125;
  localparam logic [DIV_W-1:0]  CONV_BIAS   = 36'd220288;
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2700;

  // The rounding divisor 440576 is 256 * 1721. The numerator is shifted down
  // by 8 and then multiplied by ceil(2^39 / 1721), which gives the exact
  // quotient for every shifted numerator below 2^28.
  localparam int CONV_PRE  = 8;
  localparam int RECIP_W   = 29;
  localparam int CONV_POST = 39;
  localparam int PROD_W    = DIV_W - CONV_PRE + RECIP_W;
  localparam logic [RECIP_W-1:0] CONV_RECIP = 29'd319439753;

endpackage : tsma_pkg

`default_nettype wire

@@ hw/rtl/tsma_if.sv @@
`default_nettype none

// Input channel: one ADC code per beat.
interface tsma_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsma_pkg::CODE_W-1:0]   adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface : tsma_in_if

// Output channel: converted sample, rounded average and fill count per beat.
interface tsma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tsma_pkg::TEMP_W-1:0]   sample_temp;
  logic signed [tsma_pkg::TEMP_W-1:0]   moving_avg;
  logic        [tsma_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output sample_temp, output moving_avg,
                  output fill_count, input ready);
  modport sink   (input valid, input sample_temp, input moving_avg,
                  input fill_count, output ready);
endinterface : tsma_out_if

`default_nettype wire

@@ hw/rtl/temp_sensor_moving_average_core.sv @@
// Temperature sensor moving average core.
// The input channel in_i takes one raw 12-bit sensor code per beat. For every
// input beat the output channel out_o gives exactly one beat carrying the
// converted sample (signed hundredths of a degree Celsius), the rounded mean
// of the samples in the window, and how many samples that mean covers.
// The conversion goes through a multiply step, a reciprocal multiply step
// for the constant division and a step that forms the sample; then come
// the window update, the divider set-up, the 18 steps of the restoring
// divider for the average and the output load, after which the core
// returns to idle, where it takes the next beat.
// The core works on one beat at a time; in_i.ready is high while it is idle.
// A finished result sits in the output register, so a new input beat is
// taken while the previous result still waits for the receiver. If the
// receiver stalls long enough for the next result to be ready, the core
// holds that result internally until the output register is free.
// Reset empties the window: the running sum, the write slot and the fill
// count return to zero, and unwritten ring entries are treated as zero
// through the fill count, so no clearing pass is needed.

`default_nettype none

module temp_sensor_moving_average_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  tsma_in_if.sink       in_i,
  tsma_out_if.source    out_o
);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_REC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_TEMP = 3'd7;

  localparam int TW = tsma_pkg::TEMP_W;
  localparam int SW = tsma_pkg::SUM_W;
  localparam int DW = tsma_pkg::DIV_W;
  localparam int QW = tsma_pkg::QW;

  logic [2:0] state_q, state_d;

  // Window state held in registers beside the ring memory.
  logic signed [SW-1:0]              sum_q, sum_d;
  logic [tsma_pkg::SLOT_W-1:0]       slot_q, slot_d;
  logic [tsma_pkg::CNT_W-1:0]        filled_q, filled_d;

  // Working registers of the current beat.
  logic signed [tsma_pkg::X_W-1:0]   x_q;
  logic signed [TW-1:0]              old_q;
  logic signed [TW-1:0]              temp_q;
  logic signed [TW-1:0]              avg_q;
  logic [DW-1:0]                     div_r_q;
  logic [DW-1:0]                     dsh_q;
  logic [QW-1:0]                     quo_q;
  logic [tsma_pkg::CNT_DW-1:0]       cnt_q;
  logic                              neg_q;

  // Output register.
  logic                              out_valid_q;
  logic signed [TW-1:0]              out_temp_q;
  logic signed [TW-1:0]              out_avg_q;
  logic [tsma_pkg::FILL_W-1:0]       out_fill_q;

  // Ring of samples: one synchronous memory with a registered read port.
  logic signed [TW-1:0] ring_mem [tsma_pkg::WINDOW];
  logic signed [TW-1:0] ring_rd_q;
  logic                 mem_re;
  logic                 mem_we;

  logic in_fire;
  logic out_fire;
  logic out_free;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.sample_temp = out_temp_q;
  assign out_o.moving_avg  = out_avg_q;
  assign out_o.fill_count  = out_fill_q;

  // The old entry of the slot is read when the beat is taken; the new sample
  // is written to it in the update cycle. Only one beat is in flight, so the
  // read and the write of one entry can never overlap.
  assign mem_re = in_fire;
  assign mem_we = (state_q == S_UPD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= temp_q;
    end
    if (mem_re) begin
      ring_rd_q <= ring_mem[slot_q];
    end
  end

  // Front end arithmetic.
  logic [tsma_pkg::XMAG_W-1:0]   code_mul;
  logic signed [tsma_pkg::X_W-1:0] x_new;
  logic [tsma_pkg::XMAG_W-1:0]   x_mag;
  logic [DW-1:0]                 conv_num;

  assign code_mul = tsma_pkg::XMAG_W'(in_i.adc_code) * tsma_pkg::CONV_MUL;
  assign x_new    = $signed({1'b0, code_mul}) - $signed(tsma_pkg::CONV_OFFSET);
  assign x_mag    = x_q[tsma_pkg::X_W-1] ? tsma_pkg::XMAG_W'(-x_q)
                                         : x_q[tsma_pkg::XMAG_W-1:0];
  // Twice the magnitude times 3125, plus half the divisor for rounding.
  assign conv_num = {x_mag, 1'b0} * tsma_pkg::CONV_K2 + tsma_pkg::CONV_BIAS;

  // Constant division of the conversion by reciprocal multiplication.
  logic [tsma_pkg::PROD_W-1:0] rec_prod;
  logic [QW-1:0]               rec_quo;

  assign rec_prod = div_r_q[DW-1:tsma_pkg::CONV_PRE] * tsma_pkg::CONV_RECIP;
  assign rec_quo  = rec_prod[tsma_pkg::CONV_POST +: QW];

  // One restoring step of the divider for the average.
  logic          div_ge;
  logic [QW-1:0] quo_next;
  logic          div_last;

  assign div_ge   = (div_r_q >= dsh_q);
  assign quo_next = {quo_q[QW-2:0], div_ge};
  assign div_last = (cnt_q == tsma_pkg::CNT_DW'(QW - 1));

  // Converted sample and rounded average.
  logic signed [TW-1:0] temp_new;
  logic signed [TW-1:0] avg_new;

  assign temp_new = neg_q ? tsma_pkg::TEMP_BASE + $signed({1'b0, quo_q})
                          : tsma_pkg::TEMP_BASE - $signed({1'b0, quo_q});
  assign avg_new  = neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});

  // Average set-up from the updated window.
  logic [SW-1:0] sum_mag;
  logic [DW-1:0] avg_num;
  logic [DW-1:0] avg_dsh;

  assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : sum_q;
  assign avg_num = DW'({sum_mag, 1'b0}) + DW'(filled_q);
  assign avg_dsh = DW'({filled_q, 1'b0}) << (QW - 1);

  // Window update.
  logic signed [SW-1:0] old_ext;
  logic signed [SW-1:0] temp_ext;

  assign old_ext  = {{(SW - TW){old_q[TW-1]}}, old_q};
  assign temp_ext = {{(SW - TW){temp_q[TW-1]}}, temp_q};

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    slot_d   = slot_q;
    filled_d = filled_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_REC;
      end
      S_REC: begin
        state_d = S_TEMP;
      end
      S_TEMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        sum_d  = sum_q - old_ext + temp_ext;
        slot_d = (slot_q == tsma_pkg::SLOT_W'(tsma_pkg::WINDOW - 1))
                 ? '0 : slot_q + 1'b1;
        if (filled_q != tsma_pkg::CNT_W'(tsma_pkg::WINDOW)) begin
          filled_d = filled_q + 1'b1;
        end
        state_d = S_PREP;
      end
      S_PREP: begin
        state_d = S_DIV2;
      end
      S_DIV2: begin
        if (div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      slot_q      <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      slot_q   <= slot_d;
      filled_q <= filled_d;
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_q <= x_new;
        end
      end
      S_MUL: begin
        // An entry is only live once the window has wrapped.
        old_q   <= (filled_q == tsma_pkg::CNT_W'(tsma_pkg::WINDOW)) ? ring_rd_q : '0;
        neg_q   <= x_q[tsma_pkg::X_W-1];
        div_r_q <= conv_num;
      end
      S_REC: begin
        quo_q <= rec_quo;
      end
      S_TEMP: begin
        temp_q <= temp_new;
      end
      S_DIV2: begin
        div_r_q <= div_ge ? div_r_q - dsh_q : div_r_q;
        dsh_q   <= dsh_q >> 1;
        quo_q   <= quo_next;
        cnt_q   <= cnt_q + 1'b1;
        if (div_last) begin
          avg_q <= avg_new;
        end
      end
      S_PREP: begin
        neg_q   <= sum_q[SW-1];
        div_r_q <= avg_num;
        dsh_q   <= avg_dsh;
        quo_q   <= '0;
        cnt_q   <= '0;
      end
      S_OUT: begin
        if (out_free) begin
          out_temp_q <= temp_q;
          out_avg_q  <= avg_q;
          out_fill_q <= tsma_pkg::FILL_W'(filled_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Assertions.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MUL))
    else $error("accepted beat did not start the conversion");

  a_slot_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q != tsma_pkg::CNT_W'(tsma_pkg::WINDOW)) |->
      (tsma_pkg::CNT_W'(slot_q) == filled_q))
    else $error("write slot and fill count out of step before the window wrapped");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("output register loaded outside the output step");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV2) |-> (cnt_q <= tsma_pkg::CNT_DW'(QW - 1)))
    else $error("divider ran past its last step");

endmodule : temp_sensor_moving_average_core

`default_nettype wire
